// ===== hw/rtl/tma_pkg.sv =====
// shared types and constants of the triangle mesh area accumulator
`timescale 1ns / 1ps
package tma_pkg;

    localparam int SUM_BITS = 63;
    localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        B_IDLE,
        B_CROSS,
        B_SQLOAD,
        B_SQUARE,
        B_ROOT,
        B_ACC,
        B_OUT
    } back_state_t;

endpackage

// ===== hw/rtl/tma_front.sv =====
// input stage: takes triangles, forms the edge vectors b-a and c-a and registers them
`timescale 1ns / 1ps
module tma_front
    import tma_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [COORD_BITS-1:0]   s_ax,
    input  logic signed [COORD_BITS-1:0]   s_ay,
    input  logic signed [COORD_BITS-1:0]   s_az,
    input  logic signed [COORD_BITS-1:0]   s_bx,
    input  logic signed [COORD_BITS-1:0]   s_by_coord,
    input  logic signed [COORD_BITS-1:0]   s_bz,
    input  logic signed [COORD_BITS-1:0]   s_cx,
    input  logic signed [COORD_BITS-1:0]   s_cy,
    input  logic signed [COORD_BITS-1:0]   s_cz,
    input  logic                           s_last_triangle,
    output logic                           fr_valid,
    input  logic                           fr_ready,
    output logic [6*(COORD_BITS+1):0]      fr_data
);

    localparam int DW = COORD_BITS + 1;

    logic                  valid_reg;
    logic [6*DW:0]         data_reg;
    logic [6*DW:0]         data_next;
    logic signed [DW-1:0]  e0, e1, e2, f0, f1, f2;

    function automatic logic signed [DW-1:0] sdiff(
        input logic signed [COORD_BITS-1:0] u,
        input logic signed [COORD_BITS-1:0] v
    );
        return DW'(u) - DW'(v);
    endfunction

    always_comb begin
        e0 = sdiff(s_bx, s_ax);
        e1 = sdiff(s_by_coord, s_ay);
        e2 = sdiff(s_bz, s_az);
        f0 = sdiff(s_cx, s_ax);
        f1 = sdiff(s_cy, s_ay);
        f2 = sdiff(s_cz, s_az);
        data_next = {s_last_triangle, f2, f1, f0, e2, e1, e0};
    end

    assign s_ready  = !valid_reg || fr_ready;
    assign fr_valid = valid_reg;
    assign fr_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hw/rtl/tma_queue.sv =====
// two-entry queue between the input stage and the area unit
`timescale 1ns / 1ps
module tma_queue
    import tma_pkg::*;
#(
    parameter int WIDTH = 151
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hw/rtl/tma_back.sv =====
// area unit: cross product, squared length, square root and running total
`timescale 1ns / 1ps
module tma_back
    import tma_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    output logic                      q_ready,
    input  logic [6*(COORD_BITS+1):0] q_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SUM_BITS-1:0]       m_mesh_area,
    output logic                      m_area_saturated
);

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int MW = 2 * COORD_BITS + 1;
    localparam int SW = 4 * COORD_BITS + 4;
    localparam int RW = 2 * COORD_BITS + 2;
    localparam int AW = (RW - 1 > 64) ? RW - 1 : 64;
    localparam int CW = $clog2(RW + 1);

    back_state_t          state_reg, state_next;
    logic signed [DW-1:0] e_reg [3];
    logic signed [DW-1:0] f_reg [3];
    logic                 last_reg;
    logic signed [PW-1:0] k_reg [3];
    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    logic signed [DW-1:0] op_a, op_b;
    logic [2:0]           step_reg;
    logic [1:0]           comp_reg;
    logic [CW-1:0]        cnt_reg;
    logic [SW-1:0]        mcand_reg;
    logic [MW-1:0]        mplier_reg;
    logic [SW-1:0]        sq_reg;
    logic [RW+1:0]        rem_reg;
    logic [RW-1:0]        root_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic                 clip_reg;
    logic                 out_valid_reg;
    logic [SUM_BITS-1:0]  out_sum_reg;
    logic                 out_clip_reg;
    logic signed [PW-1:0] k_sel;
    logic [PW-1:0]        k_mag;
    logic [RW+1:0]        rem_w, trial;
    logic [AW-1:0]        area;
    logic                 big;
    logic [SUM_BITS:0]    sum_w;
    logic                 pop;
    logic                 out_load;

    always_comb begin
        case (step_reg)
            3'd0:    begin op_a = e_reg[1]; op_b = f_reg[2]; end
            3'd1:    begin op_a = e_reg[2]; op_b = f_reg[1]; end
            3'd2:    begin op_a = e_reg[2]; op_b = f_reg[0]; end
            3'd3:    begin op_a = e_reg[0]; op_b = f_reg[2]; end
            3'd4:    begin op_a = e_reg[0]; op_b = f_reg[1]; end
            default: begin op_a = e_reg[1]; op_b = f_reg[0]; end
        endcase
        prod_next = PW'(op_a) * PW'(op_b);
        k_sel = k_reg[comp_reg];
        k_mag = k_sel[PW-1] ? PW'(-k_sel) : PW'(k_sel);
        rem_w = {rem_reg[RW-1:0], sq_reg[SW-1 -: 2]};
        trial = {root_reg, 2'b01};
        area  = AW'(root_reg >> 1);
        big   = |area[AW-1:SUM_BITS];
        sum_w = {1'b0, sum_reg} + {1'b0, area[SUM_BITS-1:0]};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (q_valid) state_next = B_CROSS;
            B_CROSS:  if (step_reg == 3'd6) state_next = B_SQLOAD;
            B_SQLOAD: state_next = B_SQUARE;
            B_SQUARE: begin
                if (cnt_reg == CW'(MW - 1)) begin
                    state_next = (comp_reg == 2'd2) ? B_ROOT : B_SQLOAD;
                end
            end
            B_ROOT:   if (cnt_reg == CW'(RW - 1)) state_next = B_ACC;
            B_ACC:    state_next = last_reg ? B_OUT : B_IDLE;
            B_OUT:    if (!out_valid_reg || m_ready) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop      = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            B_IDLE:  pop = q_valid;
            B_OUT:   out_load = !out_valid_reg || m_ready;
            default: begin
                pop      = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign q_ready          = pop;
    assign m_valid          = out_valid_reg;
    assign m_mesh_area      = out_sum_reg;
    assign m_area_saturated = out_clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                clip_reg      <= 1'b0;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == B_ACC && area != '0) begin
                if (big || sum_w[SUM_BITS]) begin
                    sum_reg  <= SUM_MAX;
                    clip_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_w[SUM_BITS-1:0];
                end
            end
        end
        if (out_load) begin
            out_sum_reg  <= sum_reg;
            out_clip_reg <= clip_reg;
        end
        case (state_reg)
            B_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    e_reg[i] <= q_data[i*DW +: DW];
                    f_reg[i] <= q_data[(i+3)*DW +: DW];
                    k_reg[i] <= '0;
                end
                last_reg <= q_data[6*DW];
                step_reg <= 3'd0;
                comp_reg <= 2'd0;
                sq_reg   <= '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            B_CROSS: begin
                prod_reg <= prod_next;
                step_reg <= step_reg + 3'd1;
                if (step_reg != 3'd0) begin
                    if (step_reg[0]) begin
                        k_reg[step_reg[2:1]] <= k_reg[step_reg[2:1]] + prod_reg;
                    end else begin
                        k_reg[step_reg[2:1] - 2'd1] <= k_reg[step_reg[2:1] - 2'd1] - prod_reg;
                    end
                end
            end
            B_SQLOAD: begin
                mcand_reg  <= SW'(k_mag);
                mplier_reg <= k_mag[MW-1:0];
                cnt_reg    <= '0;
            end
            B_SQUARE: begin
                if (mplier_reg[0]) begin
                    sq_reg <= sq_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
                cnt_reg    <= (cnt_reg == CW'(MW - 1)) ? '0 : cnt_reg + CW'(1);
                if (cnt_reg == CW'(MW - 1)) begin
                    comp_reg <= comp_reg + 2'd1;
                end
            end
            B_ROOT: begin
                sq_reg  <= sq_reg << 2;
                cnt_reg <= cnt_reg + CW'(1);
                if (rem_w >= trial) begin
                    rem_reg  <= rem_w - trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_w;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            default: begin
                cnt_reg <= cnt_reg;
            end
        endcase
    end

endmodule

// ===== hw/rtl/triangle_mesh_area_accumulator.sv =====
// top level of the triangle mesh area accumulator
// Input channel s_*: one triangle per item, three vertices of signed Q.8
// coordinates plus s_last_triangle marking the end of a mesh.
// Output channel m_*: one item per mesh, the summed area in Q.16 units
// (saturating at 2^63-1) and a flag that the total clipped.
// Each triangle passes an input register that forms the edge vectors and a
// two-entry queue, then the area unit: cross product with one shared
// multiplier, bit-serial squaring of the three components and a
// one-bit-per-cycle square root. The area unit sets the rate: it takes no
// new triangle until it is through with the previous one, and at the end of
// a mesh it also waits until the output register is free.
// Up to three more triangles are taken while the area unit is busy.
// Reset clears the total, the queue and the output register.
// While m_ready is low the result waits in the output register; the next
// mesh keeps accumulating until its own result needs that register.
`timescale 1ns / 1ps
module triangle_mesh_area_accumulator
    import tma_pkg::*;
#(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_ax,
    input  logic signed [COORD_BITS-1:0]  s_ay,
    input  logic signed [COORD_BITS-1:0]  s_az,
    input  logic signed [COORD_BITS-1:0]  s_bx,
    input  logic signed [COORD_BITS-1:0]  s_by_coord,
    input  logic signed [COORD_BITS-1:0]  s_bz,
    input  logic signed [COORD_BITS-1:0]  s_cx,
    input  logic signed [COORD_BITS-1:0]  s_cy,
    input  logic signed [COORD_BITS-1:0]  s_cz,
    input  logic                          s_last_triangle,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [SUM_BITS-1:0]           m_mesh_area,
    output logic                          m_area_saturated
);

    localparam int QW = 6 * (COORD_BITS + 1) + 1;

    logic          fr_valid, fr_ready;
    logic [QW-1:0] fr_data;
    logic          q_valid, q_ready;
    logic [QW-1:0] q_data;

    tma_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_ax(s_ax), .s_ay(s_ay), .s_az(s_az),
        .s_bx(s_bx), .s_by_coord(s_by_coord), .s_bz(s_bz),
        .s_cx(s_cx), .s_cy(s_cy), .s_cz(s_cz),
        .s_last_triangle(s_last_triangle),
        .fr_valid(fr_valid), .fr_ready(fr_ready), .fr_data(fr_data)
    );

    tma_queue #(.WIDTH(QW)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fr_valid), .in_ready(fr_ready), .in_data(fr_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    tma_back #(.COORD_BITS(COORD_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_mesh_area(m_mesh_area), .m_area_saturated(m_area_saturated)
    );

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_ready |-> q_valid)
        else $error("area unit took an item from an empty queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> fr_valid)
        else $error("input stalled with an empty input register");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_area_saturated) |-> (m_mesh_area == SUM_MAX))
        else $error("saturated total below its maximum");

endmodule

// ===== verif/triangle_mesh_area_accumulator_tb.sv =====
// testbench for the triangle mesh area accumulator: directed and random meshes checked against a predictor
`timescale 1ns / 1ps
module triangle_mesh_area_accumulator_tb;
    import tma_pkg::*;

    localparam int CB = 24;
    localparam int SUM_W = SUM_BITS;

    typedef struct {
        logic signed [CB-1:0] v[9];
        bit                   last;
    } triangle_t;

    typedef struct {
        logic [SUM_W-1:0] total;
        bit               clipped;
    } mesh_total_t;

    class mesh_area_board;
        mesh_total_t      totals_q[$];
        logic [SUM_W-1:0] run_sum;
        bit               run_clip;
        int               errors;

        function new();
            run_sum  = '0;
            run_clip = 0;
            errors   = 0;
        endfunction

        function logic [63:0] int_sqrt(logic [127:0] x);
            logic [127:0] r;
            logic [127:0] t;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                t = r | (128'd1 << b);
                if (t * t <= x) r = t;
            end
            return r[63:0];
        endfunction

        function logic [127:0] square_of(longint k);
            logic [127:0] m;
            m = (k < 0) ? -k : k;
            return m * m;
        endfunction

        function logic [63:0] triangle_area(triangle_t t);
            longint e[3];
            longint f[3];
            longint k0, k1, k2;
            logic [127:0] len_sq;
            logic [63:0] len;
            for (int i = 0; i < 3; i++) begin
                e[i] = longint'(t.v[3+i]) - longint'(t.v[i]);
                f[i] = longint'(t.v[6+i]) - longint'(t.v[i]);
            end
            k0 = e[1] * f[2] - e[2] * f[1];
            k1 = e[2] * f[0] - e[0] * f[2];
            k2 = e[0] * f[1] - e[1] * f[0];
            len_sq = square_of(k0) + square_of(k1) + square_of(k2);
            len = int_sqrt(len_sq);
            return len >> 1;
        endfunction

        function void note_triangle(triangle_t t);
            logic [63:0] area;
            logic [64:0] sum;
            mesh_total_t r;
            area = triangle_area(t);
            if (area != 0) begin
                if (area[63]) begin
                    run_sum  = SUM_MAX;
                    run_clip = 1;
                end else begin
                    sum = {2'b0, run_sum} + {1'b0, area};
                    if (sum > {2'b0, SUM_MAX}) begin
                        run_sum  = SUM_MAX;
                        run_clip = 1;
                    end else begin
                        run_sum = sum[SUM_W-1:0];
                    end
                end
            end
            if (t.last) begin
                r.total   = run_sum;
                r.clipped = run_clip;
                totals_q = {totals_q, r};
                run_sum  = '0;
                run_clip = 0;
            end
        endfunction

        function void check_total(logic [SUM_W-1:0] total, logic clipped);
            mesh_total_t x;
            if (totals_q.size() == 0) begin
                $error("unexpected result item mesh_area=%0d", total);
                errors++;
                return;
            end
            x = totals_q.pop_front();
            if (total !== x.total) begin
                $error("mesh_area expected %0d actual %0d", x.total, total);
                errors++;
            end
            if (clipped !== x.clipped) begin
                $error("area_saturated expected %0d actual %0d", x.clipped, clipped);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [CB-1:0] s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz;
    logic                 s_last_triangle;
    logic                 m_valid;
    logic                 m_ready;
    logic [SUM_W-1:0]     m_mesh_area;
    logic                 m_area_saturated;

    mesh_area_board board = new();
    bit hold_long  = 0;
    bit ready_full = 0;

    triangle_mesh_area_accumulator #(.COORD_BITS(CB)) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_ax             (s_ax),
        .s_ay             (s_ay),
        .s_az             (s_az),
        .s_bx             (s_bx),
        .s_by_coord       (s_by_coord),
        .s_bz             (s_bz),
        .s_cx             (s_cx),
        .s_cy             (s_cy),
        .s_cz             (s_cz),
        .s_last_triangle  (s_last_triangle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_mesh_area      (m_mesh_area),
        .m_area_saturated (m_area_saturated)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #30ms;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_total(m_mesh_area, m_area_saturated);
    end

    // receiver with random stalls and one long hold-off on request
    initial begin
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_long) begin
                m_ready <= 0;
                repeat (3000) @(posedge aclk);
                hold_long = 0;
            end else if (ready_full) begin
                m_ready <= 1;
            end else if ($urandom_range(0, 19) == 0) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 60)) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    task automatic send_triangle(triangle_t t, int gap);
        s_valid         <= 1;
        s_ax            <= t.v[0];
        s_ay            <= t.v[1];
        s_az            <= t.v[2];
        s_bx            <= t.v[3];
        s_by_coord      <= t.v[4];
        s_bz            <= t.v[5];
        s_cx            <= t.v[6];
        s_cy            <= t.v[7];
        s_cz            <= t.v[8];
        s_last_triangle <= t.last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_triangle(t);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int kind);
        case (kind)
            0: return CB'($urandom);
            1: return CB'(int'($urandom_range(0, 512)) - 256);
            2: return $urandom_range(0, 1) ? {1'b0, {(CB-1){1'b1}}} : {1'b1, {(CB-1){1'b0}}};
            default: return CB'(int'($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    function automatic triangle_t rand_triangle(bit last);
        triangle_t t;
        int kind;
        int shape;
        kind  = $urandom_range(0, 3);
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) t.v[i] = rand_coord(kind);
        // degenerate: one vertex repeated
        if (shape == 0) for (int i = 0; i < 3; i++) t.v[3+i] = t.v[i];
        if (shape == 1) for (int i = 0; i < 3; i++) t.v[6+i] = t.v[3+i];
        if (shape == 2) for (int i = 0; i < 3; i++) t.v[6+i] = t.v[i];
        t.last = last;
        return t;
    endfunction

    function automatic triangle_t fixed_triangle(int a, int b, int c, bit last);
        triangle_t t;
        logic signed [CB-1:0] lo, hi;
        lo = {1'b1, {(CB-1){1'b0}}};
        hi = {1'b0, {(CB-1){1'b1}}};
        for (int i = 0; i < 9; i++) t.v[i] = '0;
        t.v[0] = CB'(a); t.v[4] = CB'(b); t.v[8] = CB'(c);
        if (a == 1) begin
            for (int i = 0; i < 3; i++) t.v[i] = lo;
            t.v[3] = hi; t.v[4] = lo; t.v[5] = lo;
            t.v[6] = lo; t.v[7] = hi; t.v[8] = lo;
        end
        if (a == 2) begin
            for (int i = 0; i < 3; i++) t.v[i] = hi;
            t.v[3] = lo; t.v[4] = hi; t.v[5] = lo;
            t.v[6] = lo; t.v[7] = lo; t.v[8] = hi;
        end
        t.last = last;
        return t;
    endfunction

    initial begin
        triangle_t t;
        int sent;
        aresetn = 0;
        s_valid = 0;
        {s_ax, s_ay, s_az, s_bx, s_by_coord, s_bz, s_cx, s_cy, s_cz} = '0;
        s_last_triangle = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, degenerate, single and multi triangle meshes
        ready_full = 1;
        send_triangle(fixed_triangle(1, 0, 0, 1), 0);
        send_triangle(fixed_triangle(2, 0, 0, 1), 0);
        send_triangle(fixed_triangle(0, 256, 256, 1), 1);
        send_triangle(fixed_triangle(0, 0, 0, 1), 2);
        send_triangle(fixed_triangle(1, 0, 0, 0), 0);
        send_triangle(fixed_triangle(2, 0, 0, 0), 0);
        send_triangle(fixed_triangle(0, 0, 0, 0), 0);
        send_triangle(fixed_triangle(0, 1, 1, 1), 3);
        for (int i = 0; i < 6; i++) begin
            t = rand_triangle(i % 3 == 2);
            for (int k = 0; k < 3; k++) t.v[3+k] = t.v[k];
            send_triangle(t, 0);
        end
        for (int i = 0; i < 8; i++) begin
            t = rand_triangle((i % 2) == 1);
            send_triangle(t, pick_gap());
        end
        ready_full = 0;

        // back-pressure: long receiver hold while short meshes keep coming
        hold_long = 1;
        for (int i = 0; i < 20; i++) send_triangle(rand_triangle($urandom_range(0, 1) == 1), 0);

        // sender pause until the pipeline is drained
        s_valid <= 0;
        while (board.totals_q.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);

        sent = 0;
        while (sent < 2000) begin
            int mesh_len;
            mesh_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            if ($urandom_range(0, 9) == 0) ready_full = ~ready_full;
            for (int i = 0; i < mesh_len; i++) begin
                send_triangle(rand_triangle(i == mesh_len - 1), pick_gap());
                sent++;
            end
        end
        // a trailing triangle without a closing marker produces nothing
        send_triangle(rand_triangle(0), 1);
        s_valid <= 0;

        while (board.totals_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
